// ----- hw/rtl/aarch64_pc_relative_relocator_unit_assert.svh -----
// assertion macros used by the relocator checker
`ifndef AARCH64_PC_RELATIVE_RELOCATOR_UNIT_ASSERT_SVH
`define AARCH64_PC_RELATIVE_RELOCATOR_UNIT_ASSERT_SVH

// clocked assertion, muted while reset is active
`define A64REL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define A64REL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/a64rel_pkg.sv -----
// ----------------------------------------------------------------------------
// a64rel_pkg
// types and opcode constants of the aarch64 pc-relative relocator
// ----------------------------------------------------------------------------
`default_nettype none

package a64rel_pkg;

	// instruction class after decode
	typedef enum logic [2:0] {
		CLS_COPY,
		CLS_B26,
		CLS_IMM19,
		CLS_TB14,
		CLS_ADR,
		CLS_ADRP
	} cls_t;

	// result status codes
	localparam logic [1:0] ST_COPY  = 2'd0;
	localparam logic [1:0] ST_RELOC = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// decode masks and match values
	localparam logic [31:0] B_MASK     = 32'h7C00_0000;
	localparam logic [31:0] B_MATCH    = 32'h1400_0000;
	localparam logic [31:0] BC_MASK    = 32'hFF00_0010;
	localparam logic [31:0] BC_MATCH   = 32'h5400_0000;
	localparam logic [31:0] CB_MASK    = 32'h7E00_0000;
	localparam logic [31:0] CB_MATCH   = 32'h3400_0000;
	localparam logic [31:0] TB_MATCH   = 32'h3600_0000;
	localparam logic [31:0] ADR_MASK   = 32'h1F00_0000;
	localparam logic [31:0] ADR_MATCH  = 32'h1000_0000;
	localparam logic [7:0]  LDR_W_OP   = 8'h18;
	localparam logic [7:0]  LDR_X_OP   = 8'h58;
	localparam logic [7:0]  LDRSW_OP   = 8'h98;

	// bits kept from the original word on re-encode
	localparam logic [31:0] KEEP_B26   = 32'hFC00_0000;
	localparam logic [31:0] KEEP_IMM19 = 32'hFF00_001F;
	localparam logic [31:0] KEEP_TB14  = 32'hFFF8_001F;
	localparam logic [31:0] KEEP_ADR   = 32'h9F00_001F;

	localparam logic [63:0] PAGE_MASK  = 64'hFFFF_FFFF_FFFF_F000;

endpackage

`default_nettype wire

// ----- hw/rtl/aarch64_pc_relative_relocator_unit.sv -----
// ----------------------------------------------------------------------------
// aarch64_pc_relative_relocator_unit
// re-encodes pc-relative aarch64 instructions for a new address
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// in      | in_valid / in_ready  | instruction, old_pc, new_pc
// out     | out_valid / out_ready| new_instruction, status
//
// four register stages: decode, target add, distance subtract, range check
// and encode. one item per cycle unless the output stalls; an accepted item
// is held in each stage register in turn before out_valid rises.
// reset clears the stage valid bits only. a stall at the output holds every
// stage that is full; empty stages keep filling, so no item is lost or doubled.
`default_nettype none

module aarch64_pc_relative_relocator_unit import a64rel_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] instruction,
	input  wire logic [63:0] old_pc,
	input  wire logic [63:0] new_pc,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      new_instruction,
	output logic [1:0]       status
);

	logic adv1, adv2, adv3, adv4;

	logic        v_s1, v_s2, v_s3, v_s4;
	cls_t        cls_s1, cls_s2, cls_s3;
	logic [31:0] instr_s1, instr_s2, instr_s3;
	logic [63:0] base_s1, imm_s1, npc_s1;
	logic [63:0] tgt_s2, npc_s2;
	logic [63:0] diff_s3;
	logic [31:0] new_instruction_s4;
	logic [1:0]  status_s4;

	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// stage 1 decode
	cls_t        dec_cls;
	logic [63:0] dec_imm;
	logic [20:0] adr_imm;

	always_comb begin
		adr_imm = {instruction[23:5], instruction[30:29]};
		dec_cls = CLS_COPY;
		dec_imm = '0;
		if ((instruction & B_MASK) == B_MATCH) begin
			dec_cls = CLS_B26;
			dec_imm = {{36{instruction[25]}}, instruction[25:0], 2'b00};
		end else if ((instruction & BC_MASK) == BC_MATCH ||
			(instruction & CB_MASK) == CB_MATCH) begin
			dec_cls = CLS_IMM19;
			dec_imm = {{43{instruction[23]}}, instruction[23:5], 2'b00};
		end else if ((instruction & CB_MASK) == TB_MATCH) begin
			dec_cls = CLS_TB14;
			dec_imm = {{48{instruction[18]}}, instruction[18:5], 2'b00};
		end else if ((instruction & ADR_MASK) == ADR_MATCH) begin
			if (instruction[31]) begin
				dec_cls = CLS_ADRP;
				dec_imm = {{31{adr_imm[20]}}, adr_imm, 12'h000};
			end else begin
				dec_cls = CLS_ADR;
				dec_imm = {{43{adr_imm[20]}}, adr_imm};
			end
		end else if (instruction[31:24] == LDR_W_OP || instruction[31:24] == LDR_X_OP ||
			instruction[31:24] == LDRSW_OP) begin
			dec_cls = CLS_IMM19;
			dec_imm = {{43{instruction[23]}}, instruction[23:5], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			cls_s1   <= dec_cls;
			instr_s1 <= instruction;
			imm_s1   <= dec_imm;
			// adrp works on page addresses
			base_s1  <= (dec_cls == CLS_ADRP) ? (old_pc & PAGE_MASK) : old_pc;
			npc_s1   <= (dec_cls == CLS_ADRP) ? (new_pc & PAGE_MASK) : new_pc;
		end
	end

	// stage 2 target address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			cls_s2   <= cls_s1;
			instr_s2 <= instr_s1;
			tgt_s2   <= base_s1 + imm_s1;
			npc_s2   <= npc_s1;
		end
	end

	// stage 3 distance from the new address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			cls_s3   <= cls_s2;
			instr_s3 <= instr_s2;
			diff_s3  <= tgt_s2 - npc_s2;
		end
	end

	// stage 4 range check and encode
	logic [63:0] off;
	logic        fit;
	logic [31:0] enc_word;
	logic [1:0]  enc_status;

	always_comb begin
		case (cls_s3)
			CLS_ADRP: off = 64'($signed(diff_s3) >>> 12);
			CLS_ADR:  off = diff_s3;
			default:  off = 64'($signed(diff_s3) >>> 2);
		endcase
	end

	always_comb begin
		case (cls_s3)
			CLS_B26:   fit = (&off[63:25]) || !(|off[63:25]);
			CLS_IMM19: fit = (&off[63:18]) || !(|off[63:18]);
			CLS_TB14:  fit = (&off[63:13]) || !(|off[63:13]);
			CLS_ADR,
			CLS_ADRP:  fit = (&off[63:20]) || !(|off[63:20]);
			default:   fit = 1'b1;
		endcase
	end

	always_comb begin
		case (cls_s3)
			CLS_B26:   enc_word = (instr_s3 & KEEP_B26) | {6'h00, off[25:0]};
			CLS_IMM19: enc_word = (instr_s3 & KEEP_IMM19) | {8'h00, off[18:0], 5'h00};
			CLS_TB14:  enc_word = (instr_s3 & KEEP_TB14) | {13'd0, off[13:0], 5'h00};
			CLS_ADR,
			CLS_ADRP:  enc_word = (instr_s3 & KEEP_ADR) |
				{1'b0, off[1:0], 5'h00, off[20:2], 5'h00};
			default:   enc_word = instr_s3;
		endcase
		if (cls_s3 == CLS_COPY) begin
			enc_status = ST_COPY;
		end else if (fit) begin
			enc_status = ST_RELOC;
		end else begin
			enc_status = ST_RANGE;
			enc_word   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			new_instruction_s4 <= enc_word;
			status_s4          <= enc_status;
		end
	end

	assign out_valid       = v_s4;
	assign new_instruction = new_instruction_s4;
	assign status          = status_s4;

endmodule

`default_nettype wire

// ----- hw/rtl/a64rel_checker.sv -----
// ----------------------------------------------------------------------------
// a64rel_checker
// port-level checks of the relocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "aarch64_pc_relative_relocator_unit_assert.svh"

module a64rel_checker import a64rel_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [31:0] instruction,
	input wire logic [63:0] old_pc,
	input wire logic [63:0] new_pc,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] new_instruction,
	input wire logic [1:0]  status
);

	`A64REL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out item dropped while stalled")
	`A64REL_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(new_instruction) && $stable(status), "out item changed while stalled")
	`A64REL_ASSERT(a_status_code, out_valid |-> (status == ST_COPY || status == ST_RELOC || status == ST_RANGE), "undefined status code")
	`A64REL_ASSERT(a_range_zero, out_valid && status == ST_RANGE |-> new_instruction == 32'h0, "out of range item carries a nonzero word")
	`A64REL_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !out_valid, "out valid during reset")

endmodule

bind aarch64_pc_relative_relocator_unit a64rel_checker u_a64rel_checker (.*);

`default_nettype wire
